/* src/slx_pkg.sv */
// Shared types, character codes and character-class helpers for the SQL token lexer.
package slx_pkg;

    // Default number of identifier bytes held back for keyword matching.
    localparam int KEYWORD_HOLD_DEF = 6;

    // Number of runs the queue between front and back can hold.
    localparam int QUEUE_DEPTH = 4;

    // Token classes as they appear on the output; KIND_NONE marks no open token.
    typedef enum logic [2:0] {
        KIND_NUM   = 3'd0,
        KIND_QUOTE = 3'd1,
        KIND_IDENT = 3'd2,
        KIND_KEY   = 3'd3,
        KIND_OP    = 3'd4,
        KIND_OTHER = 3'd5,
        KIND_NONE  = 3'd7
    } t_slx_kind;

    // One input beat.
    typedef struct packed {
        logic [7:0] char_in;
        logic       final_req;
    } t_slx_in;

    // One output beat.
    typedef struct packed {
        logic [7:0] char_out;
        logic [2:0] kind;
        logic       first_of_token;
        logic       last_of_token;
        logic       last_of_run;
    } t_slx_out;

    // One token character as produced by the front, before run marking.
    typedef struct packed {
        logic [7:0] ch;
        t_slx_kind  kind;
        logic       first;
        logic       last;
    } t_slx_res;

    // Character codes.
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    // Keywords, first character in the most significant byte.
    localparam logic [47:0] KW_SELECT = "SELECT";
    localparam logic [31:0] KW_FROM   = "FROM";
    localparam logic [39:0] KW_WHERE  = "WHERE";
    localparam logic [23:0] KW_AND    = "AND";
    localparam logic [15:0] KW_OR     = "OR";

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic is_identc(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || (c == CH_UNDER);
    endfunction

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) ? (c - 8'd32) : c;
    endfunction

endpackage

/* src/slx_front.sv */
// Front end: accepts query bytes, runs the tokenizer state and builds one run of results.
module slx_front
    import slx_pkg::*;
#(
    parameter int KEYWORD_HOLD = KEYWORD_HOLD_DEF,
    localparam int RunW = $clog2(KEYWORD_HOLD + 2)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  t_slx_in                    i_in_data,
    output logic                       o_in_ready,
    input  logic                       i_room,
    output logic                       o_push,
    output t_slx_res [KEYWORD_HOLD:0]  o_run,
    output logic [RunW-1:0]            o_run_cnt
);

    localparam int CntW  = $clog2(KEYWORD_HOLD + 1);
    localparam int HoldW = $clog2(KEYWORD_HOLD);

    typedef struct packed {
        t_slx_kind       open;
        logic [CntW-1:0] cnt;
        logic            first;
        logic            dot;
        logic [7:0]      quote;
        logic            esc;
    } t_slx_lex_state;

    localparam t_slx_lex_state StIdle = '{open: KIND_NONE, default: '0};

    t_slx_lex_state            r_st;
    t_slx_lex_state            n_st;
    logic [7:0]                r_held [KEYWORD_HOLD];
    logic [7:0]                n_held [KEYWORD_HOLD];

    t_slx_res [KEYWORD_HOLD:0] run_res;
    logic [RunW-1:0]           run_n;
    logic [RunW-1:0]           pos;
    logic [7:0]                c;
    logic                      fin;
    logic                      do_close;
    logic                      do_start;
    logic                      q_last;
    logic                      key;
    logic                      accept;

    assign c          = i_in_data.char_in;
    assign fin        = i_in_data.final_req;
    assign o_in_ready = i_room;
    assign accept     = i_in_valid && o_in_ready;

    // Next state and the run of token characters caused by this byte.
    always_comb begin
        n_st     = r_st;
        n_held   = r_held;
        run_res  = '0;
        run_n    = '0;
        pos      = '0;
        do_close = 1'b0;
        do_start = 1'b0;
        q_last   = 1'b0;
        key      = 1'b0;

        case (r_st.open)
            KIND_NUM: begin
                if (is_digit(c) || (c == CH_DOT && !r_st.dot)) begin
                    run_res[run_n[CntW-1:0]] =
                        '{ch: r_held[0], kind: KIND_NUM, first: !r_st.first, last: 1'b0};
                    run_n       = run_n + 1'b1;
                    n_st.first  = 1'b1;
                    if (c == CH_DOT) begin
                        n_st.dot = 1'b1;
                    end
                    n_held[0]   = c;
                end else begin
                    do_close = 1'b1;
                    do_start = 1'b1;
                end
            end
            KIND_IDENT: begin
                if (is_identc(c)) begin
                    if (r_st.first) begin
                        run_res[run_n[CntW-1:0]] =
                            '{ch: r_held[0], kind: KIND_IDENT, first: 1'b0, last: 1'b0};
                        run_n     = run_n + 1'b1;
                        n_held[0] = c;
                    end else if (r_st.cnt < CntW'(KEYWORD_HOLD)) begin
                        n_held[r_st.cnt[HoldW-1:0]] = c;
                        n_st.cnt = r_st.cnt + 1'b1;
                    end else begin
                        // Hold is full: release it as a plain identifier.
                        for (int i = 0; i < KEYWORD_HOLD; i++) begin
                            run_res[i] = '{ch: r_held[i], kind: KIND_IDENT,
                                           first: (i == 0), last: 1'b0};
                        end
                        run_n      = RunW'(KEYWORD_HOLD);
                        n_held[0]  = c;
                        n_st.cnt   = CntW'(1);
                        n_st.first = 1'b1;
                    end
                end else begin
                    do_close = 1'b1;
                    do_start = 1'b1;
                end
            end
            KIND_QUOTE: begin
                if (r_st.esc) begin
                    n_st.esc = 1'b0;
                end else if (c == r_st.quote) begin
                    q_last = 1'b1;
                end else if (c == CH_BSLASH) begin
                    n_st.esc = 1'b1;
                end
                run_res[run_n[CntW-1:0]] =
                    '{ch: c, kind: KIND_QUOTE, first: 1'b0, last: q_last};
                run_n = run_n + 1'b1;
                if (q_last) begin
                    n_st = StIdle;
                end
            end
            KIND_OP: begin
                if ((r_held[0] == CH_GT && c == CH_EQ) ||
                    (r_held[0] == CH_LT && (c == CH_EQ || c == CH_GT))) begin
                    run_res[0] = '{ch: r_held[0], kind: KIND_OP, first: 1'b1, last: 1'b0};
                    run_res[1] = '{ch: c, kind: KIND_OP, first: 1'b0, last: 1'b1};
                    run_n      = RunW'(2);
                    n_st       = StIdle;
                end else begin
                    do_close = 1'b1;
                    do_start = 1'b1;
                end
            end
            default: begin
                do_start = 1'b1;
            end
        endcase

        // First pass closes the token this byte ended and starts a new one;
        // the second pass flushes whatever is still open at the final byte.
        for (int p = 0; p < 2; p++) begin
            if ((p == 0 && do_close) || (p == 1 && fin)) begin
                if (p == 1 && n_st.open == KIND_QUOTE && run_n != '0) begin
                    pos = run_n - 1'b1;
                    run_res[pos[CntW-1:0]].last = 1'b1;
                end
                if (n_st.open == KIND_NUM || (n_st.open == KIND_IDENT && n_st.first)) begin
                    run_res[run_n[CntW-1:0]] =
                        '{ch: n_held[0], kind: n_st.open, first: !n_st.first, last: 1'b1};
                    run_n = run_n + 1'b1;
                end else if (n_st.open == KIND_IDENT) begin
                    key = (n_st.cnt == CntW'(6) &&
                           {to_upper(n_held[0]), to_upper(n_held[1]), to_upper(n_held[2]),
                            to_upper(n_held[3]), to_upper(n_held[4]),
                            to_upper(n_held[5])} == KW_SELECT) ||
                          (n_st.cnt == CntW'(4) &&
                           {to_upper(n_held[0]), to_upper(n_held[1]), to_upper(n_held[2]),
                            to_upper(n_held[3])} == KW_FROM) ||
                          (n_st.cnt == CntW'(5) &&
                           {to_upper(n_held[0]), to_upper(n_held[1]), to_upper(n_held[2]),
                            to_upper(n_held[3]), to_upper(n_held[4])} == KW_WHERE) ||
                          (n_st.cnt == CntW'(3) &&
                           {to_upper(n_held[0]), to_upper(n_held[1]),
                            to_upper(n_held[2])} == KW_AND) ||
                          (n_st.cnt == CntW'(2) &&
                           {to_upper(n_held[0]), to_upper(n_held[1])} == KW_OR);
                    for (int i = 0; i < KEYWORD_HOLD; i++) begin
                        if (CntW'(i) < n_st.cnt) begin
                            pos = run_n + RunW'(i);
                            run_res[pos[CntW-1:0]] =
                                '{ch: key ? to_upper(n_held[i]) : n_held[i],
                                  kind: key ? KIND_KEY : KIND_IDENT,
                                  first: (i == 0),
                                  last: (CntW'(i + 1) == n_st.cnt)};
                        end
                    end
                    run_n = run_n + RunW'(n_st.cnt);
                end else if (n_st.open == KIND_OP) begin
                    run_res[run_n[CntW-1:0]] =
                        '{ch: n_held[0], kind: KIND_OP, first: 1'b1, last: 1'b1};
                    run_n = run_n + 1'b1;
                end
                n_st = StIdle;
            end
            if (p == 0 && do_start) begin
                n_st = StIdle;
                if (is_space(c)) begin
                    n_st = StIdle;
                end else if (is_digit(c)) begin
                    n_st.open = KIND_NUM;
                    n_st.cnt  = CntW'(1);
                    n_held[0] = c;
                end else if (c == CH_SQUOTE || c == CH_DQUOTE) begin
                    run_res[run_n[CntW-1:0]] =
                        '{ch: c, kind: KIND_QUOTE, first: 1'b1, last: 1'b0};
                    run_n      = run_n + 1'b1;
                    n_st.open  = KIND_QUOTE;
                    n_st.quote = c;
                end else if (is_alpha(c) || c == CH_UNDER) begin
                    n_st.open = KIND_IDENT;
                    n_st.cnt  = CntW'(1);
                    n_held[0] = c;
                end else if (c == CH_GT || c == CH_LT) begin
                    n_st.open = KIND_OP;
                    n_st.cnt  = CntW'(1);
                    n_held[0] = c;
                end else if (c == CH_EQ || c == CH_COMMA || c == CH_LPAREN ||
                             c == CH_RPAREN) begin
                    run_res[run_n[CntW-1:0]] =
                        '{ch: c, kind: KIND_OP, first: 1'b1, last: 1'b1};
                    run_n = run_n + 1'b1;
                end else begin
                    run_res[run_n[CntW-1:0]] =
                        '{ch: c, kind: KIND_OTHER, first: 1'b1, last: 1'b1};
                    run_n = run_n + 1'b1;
                end
            end
        end
    end

    // Only runs with at least one character enter the queue.
    assign o_push    = accept && (run_n != '0);
    assign o_run     = run_res;
    assign o_run_cnt = run_n;

    // Tokenizer control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= StIdle;
        end else if (accept) begin
            r_st <= n_st;
        end
    end

    // Held characters carry no reset; only written entries are read.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_held <= n_held;
        end
    end

endmodule

/* src/slx_queue.sv */
// Short queue of result runs between the lexer front and the output serialiser.
module slx_queue
    import slx_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_room,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PtrW = $clog2(DEPTH);
    localparam int CntW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PtrW-1:0]  r_wr;
    logic [PtrW-1:0]  r_rd;
    logic [CntW-1:0]  r_count;

    assign o_room  = (r_count != CntW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PtrW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PtrW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* src/slx_back.sv */
// Back end: walks the run at the queue head and sends one token character per beat.
module slx_back
    import slx_pkg::*;
#(
    parameter int KEYWORD_HOLD = KEYWORD_HOLD_DEF,
    localparam int RunW = $clog2(KEYWORD_HOLD + 2)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_head_valid,
    input  t_slx_res [KEYWORD_HOLD:0] i_run,
    input  logic [RunW-1:0]           i_run_cnt,
    output logic                      o_pop,
    output logic                      o_out_valid,
    output t_slx_out                  o_out_data,
    input  logic                      i_out_ready
);

    localparam int CntW = $clog2(KEYWORD_HOLD + 1);

    logic [CntW-1:0] r_idx;
    logic            r_out_valid;
    t_slx_out        r_out;
    logic            advance;
    logic            at_end;
    t_slx_res        cur;

    // The output register takes a new beat when empty or being drained.
    assign advance = i_head_valid && (!r_out_valid || i_out_ready);
    assign at_end  = (RunW'(r_idx) + RunW'(1)) == i_run_cnt;
    assign cur     = i_run[r_idx];
    assign o_pop   = advance && at_end;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Position within the current run and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_idx       <= at_end ? '0 : r_idx + 1'b1;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out.char_out       <= cur.ch;
            r_out.kind           <= cur.kind;
            r_out.first_of_token <= cur.first;
            r_out.last_of_token  <= cur.last;
            r_out.last_of_run    <= at_end;
        end
    end

endmodule

/* src/sql_token_lexer_top.sv */
// Top level of the streaming SQL token lexer: front, run queue and output serialiser.
//
//   Channel   Direction  Handshake                 Beat
//   input     in         i_in_valid / o_in_ready   t_slx_in  (char_in, final_req)
//   output    out        o_out_valid / i_out_ready t_slx_out (char_out, kind, marks)
//
// The front takes one byte per cycle while the run queue has a free entry; each byte
// is classified in the cycle it is accepted and its characters enter the queue as one run.
// The back sends one character per cycle while the queue holds a run and the output is not
// stalled, so a run leaves one result per beat; a full held identifier releases up to
// KEYWORD_HOLD + 1 at once. A first result goes via a queue entry and the output register.
// Reset is synchronous and clears tokenizer state, queue and output register.
// Either side may stall freely; the queue absorbs up to QUEUE_DEPTH runs.
module sql_token_lexer_top
    import slx_pkg::*;
#(
    parameter int KEYWORD_HOLD = KEYWORD_HOLD_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_slx_in  i_in_data,
    output logic     o_in_ready,
    output logic     o_out_valid,
    output t_slx_out o_out_data,
    input  logic     i_out_ready
);

    localparam int RunW    = $clog2(KEYWORD_HOLD + 2);
    localparam int RunBits = $bits(t_slx_res) * (KEYWORD_HOLD + 1);
    localparam int QW      = RunBits + RunW;

    t_slx_res [KEYWORD_HOLD:0] front_run;
    logic [RunW-1:0]           front_cnt;
    logic                      push;
    logic                      room;
    logic                      pop;
    logic                      head_valid;
    logic [QW-1:0]             head_data;
    t_slx_res [KEYWORD_HOLD:0] head_run;
    logic [RunW-1:0]           head_cnt;

    slx_front #(
        .KEYWORD_HOLD(KEYWORD_HOLD)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_ready (o_in_ready),
        .i_room     (room),
        .o_push     (push),
        .o_run      (front_run),
        .o_run_cnt  (front_cnt)
    );

    slx_queue #(
        .WIDTH(QW),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({front_cnt, front_run}),
        .o_room  (room),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_data  (head_data)
    );

    assign head_run = head_data[RunBits-1:0];
    assign head_cnt = head_data[QW-1:RunBits];

    slx_back #(
        .KEYWORD_HOLD(KEYWORD_HOLD)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_run        (head_run),
        .i_run_cnt    (head_cnt),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .o_out_data   (o_out_data),
        .i_out_ready  (i_out_ready)
    );

    // A run is only written when the queue has room for it.
    assert property (@(posedge i_clk) disable iff (!i_rst_n) push |-> room)
        else $error("run pushed into a full queue");

    // The serialiser only retires a run that is present.
    assert property (@(posedge i_clk) disable iff (!i_rst_n) pop |-> head_valid)
        else $error("run popped from an empty queue");

    // Every queued run holds at least one character.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        head_valid |-> (head_cnt != '0))
        else $error("empty run reached the queue head");

    // A delivered beat never carries the no-token class.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.kind != KIND_NONE))
        else $error("output beat without a token class");

    // Reset empties the output register.
    assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule
